// ----- hw/rtl/kfi_pkg.sv -----
package kfi_pkg;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef struct packed {
    logic        func;
    logic [5:0]  key_slot;
    logic [31:0] key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_item_t;

  localparam int unsigned KEY_W = 128;
  localparam int unsigned Q_FRAC = 16;
  localparam logic [16:0] Q_ONE = 17'h10000;

endpackage

// ----- hw/rtl/kfi_ram.sv -----
module kfi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/kfi_front.sv -----
// Front: accept transactions, split loads from queries, hold queries in a
// two-entry queue for the back end. Hold a load off until the queue is empty
// and the back end is idle, so it never overtakes an earlier query.
module kfi_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kfi_pkg::in_item_t   in_data,
  output logic                ld_we,
  output logic [5:0]          ld_slot,
  output logic [kfi_pkg::KEY_W-1:0] ld_key,
  output logic                q_valid,
  input  logic                q_ready,
  output logic [31:0]         q_time
);

  logic [31:0] fifo_r [2];
  logic        rd_ptr_r, rd_ptr_nxt;
  logic        wr_ptr_r, wr_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        acc, push, pop;

  assign in_ready = (in_data.func == kfi_pkg::FUNC_QUERY) ? (cnt_r != 2'd2)
                                                          : ((cnt_r == 2'd0) && q_ready);
  assign acc      = in_valid && in_ready;
  assign push     = acc && (in_data.func == kfi_pkg::FUNC_QUERY);
  assign pop      = q_valid && q_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_time   = fifo_r[rd_ptr_r];

  assign ld_we   = acc && (in_data.func == kfi_pkg::FUNC_LOAD);
  assign ld_slot = in_data.key_slot;
  assign ld_key  = {in_data.key_time, in_data.key_x, in_data.key_y, in_data.key_z};

  always_comb begin
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      fifo_r[wr_ptr_r] <= in_data.query_time;
    end
  end

endmodule

// ----- hw/rtl/kfi_back.sv -----
// Back: search the track one key at a time, divide serially, then lerp one
// component at a time.
module kfi_back #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [6:0]                 keys_in_use,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  logic [31:0]                q_time,
  output logic [$clog2(MAX_KEYS)-1:0] raddr,
  input  logic [kfi_pkg::KEY_W-1:0]  rdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output kfi_pkg::out_item_t         out_data
);

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned NW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_WAIT, S_LOAD0, S_LOAD1, S_DIV, S_MUL, S_ADD, S_DONE
  } state_t;

  state_t      state_r;
  logic [31:0] q_r;
  logic [NW-1:0] n_r, idx_r;
  logic [kfi_pkg::KEY_W-1:0] k0_r, k1_r;
  logic [48:0] rem_r;
  logic [31:0] den_r;
  logic [16:0] fac_r;
  logic [5:0]  dcnt_r;
  logic [1:0]  comp_r;
  logic signed [50:0] prod_r;
  logic signed [31:0] start_r;
  logic [95:0] res_r;
  logic [95:0] out_r;
  logic        out_valid_r;
  logic        last_r;

  logic [NW-1:0] n_eff;
  logic [31:0]   rtime;
  logic [49:0]   rem_sh;
  logic signed [32:0] diff;
  logic signed [31:0] a_c, b_c;
  logic signed [31:0] lerp;
  logic          done_fire;

  always_comb begin
    if (keys_in_use == 7'd0) begin
      n_eff = NW'(1);
    end else if ({25'd0, keys_in_use} > 32'(MAX_KEYS)) begin
      n_eff = NW'(MAX_KEYS);
    end else begin
      n_eff = NW'(keys_in_use);
    end
  end

  assign rtime = rdata[127:96];
  assign raddr = idx_r[AW-1:0];
  assign q_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign rem_sh = {rem_r, 1'b0};
  assign done_fire = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    case (comp_r)
      2'd0: begin a_c = k0_r[95:64]; b_c = k1_r[95:64]; end
      2'd1: begin a_c = k0_r[63:32]; b_c = k1_r[63:32]; end
      default: begin a_c = k0_r[31:0]; b_c = k1_r[31:0]; end
    endcase
    diff = 33'(b_c) - 33'(a_c);
    lerp = start_r + 32'(prod_r >>> kfi_pkg::Q_FRAC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            q_r   <= q_time;
            n_r   <= n_eff;
            if (n_eff == NW'(1)) begin
              idx_r  <= '0;
              last_r <= 1'b1;
              state_r <= S_WAIT;
            end else begin
              idx_r  <= NW'(1);
              last_r <= 1'b0;
              state_r <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          // Address idx_r is issued; data lands next cycle.
          state_r <= S_LOAD1;
        end
        S_LOAD1: begin
          if (q_r < rtime) begin
            k1_r    <= rdata;
            idx_r   <= idx_r - NW'(1);
            state_r <= S_WAIT;
          end else if (idx_r == n_r - NW'(1)) begin
            last_r  <= 1'b1;
            state_r <= S_WAIT;
          end else begin
            idx_r   <= idx_r + NW'(1);
            state_r <= S_SRCH;
          end
        end
        S_WAIT: begin
          state_r <= S_LOAD0;
        end
        S_LOAD0: begin
          k0_r <= rdata;
          if (last_r) begin
            res_r <= rdata[95:0];
            state_r <= S_DONE;
          end else begin
            den_r  <= k1_r[127:96] - rtime;
            fac_r  <= '0;
            dcnt_r <= '0;
            if (q_r <= rtime || k1_r[127:96] <= rtime) begin
              rem_r   <= '0;
              state_r <= S_MUL;
              comp_r  <= 2'd0;
            end else begin
              // Partial remainder in the upper bits, zero fraction bits below.
              rem_r   <= {1'b0, q_r - rtime, 16'd0};
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // Restoring divide of (q-t0)<<16 by den, one quotient bit a step.
          if (rem_sh[49:16] >= {2'd0, den_r}) begin
            rem_r <= {rem_sh[48:16] - {1'b0, den_r}, rem_sh[15:0]};
            fac_r <= {fac_r[15:0], 1'b1};
          end else begin
            rem_r <= rem_sh[48:0];
            fac_r <= {fac_r[15:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd15) begin
            state_r <= S_MUL;
            comp_r  <= 2'd0;
          end
        end
        S_MUL: begin
          prod_r  <= 51'(diff) * $signed({34'd0, fac_r});
          start_r <= a_c;
          state_r <= S_ADD;
        end
        S_ADD: begin
          case (comp_r)
            2'd0: res_r[95:64] <= lerp;
            2'd1: res_r[63:32] <= lerp;
            default: res_r[31:0] <= lerp;
          endcase
          if (comp_r == 2'd2) begin
            state_r <= S_DONE;
          end else begin
            comp_r  <= comp_r + 2'd1;
            state_r <= S_MUL;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/keyframe_vec3_interpolator_top.sv -----
// Keyframe interpolator for a three-component track.
// Input channel in_valid/in_ready/in_data carries load and query transactions.
// A load writes one key (time, x, y, z) into the track RAM in the cycle it is
// accepted and makes no result. A query returns one result transaction on
// out_valid/out_ready/out_data: the value linearly interpolated between the
// two keys that bracket the query time, clamped to the ends of the track.
// cfg_we/cfg_wdata set keys_in_use (reset 1); write only while idle.
// A query walks the keys one at a time, each read through the registered RAM,
// then takes 16 divide steps and a multiply and an add per component. A query
// that lies past the last of n keys skips the divide and the lerp.
// Queries are taken one at a time by the back end; a two-entry queue in the
// front lets further queries be accepted meanwhile. A load is held off until
// the queue is empty and the back end idle, so it never overtakes a query.
// A stalled receiver holds the output register; the back end finishes the
// next query and waits, the queue fills, then in_ready drops.
// Reset clears control state and sets keys_in_use to 1; the track is undefined
// until loaded.
module keyframe_vec3_interpolator_top #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kfi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kfi_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_KEYS);

  logic [6:0]  keys_r;
  logic        ld_we, q_valid, q_ready;
  logic [5:0]  ld_slot;
  logic [kfi_pkg::KEY_W-1:0] ld_key, rdata;
  logic [31:0] q_time;
  logic [AW-1:0] raddr;
  logic        wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= 7'd1;
    end else if (cfg_we) begin
      keys_r <= cfg_wdata;
    end
  end

  kfi_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .ld_we, .ld_slot, .ld_key, .q_valid, .q_ready, .q_time
  );

  // Drop loads to slots beyond the track.
  assign wr_en = ld_we && ({26'd0, ld_slot} < 32'(MAX_KEYS));

  kfi_ram #(.WIDTH(kfi_pkg::KEY_W), .DEPTH(MAX_KEYS)) u_ram (
    .clk, .we(wr_en), .waddr(AW'(ld_slot)), .wdata(ld_key),
    .raddr, .rdata
  );

  kfi_back #(.MAX_KEYS(MAX_KEYS)) u_back (
    .clk, .rst_n, .keys_in_use(keys_r), .q_valid, .q_ready, .q_time,
    .raddr, .rdata, .out_valid, .out_ready, .out_data
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> !q_ready || q_valid)
    else $error("front stalled with empty queue");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  kfi_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  kfi_pkg::out_item_t out_data;
  logic      cfg_we;
  logic [6:0] cfg_wdata;

  keyframe_vec3_interpolator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  localparam int NKEYS = 64;
  // Room to settle after the longest query walk, for a result or a late write.
  localparam int SETTLE = 250;

  always #5 clk = ~clk;

  // Own copy of the track and of the key count.
  logic [31:0] trk_time [NKEYS];
  logic [31:0] trk_x [NKEYS];
  logic [31:0] trk_y [NKEYS];
  logic [31:0] trk_z [NKEYS];
  logic [6:0]  key_count;

  kfi_pkg::out_item_t pending_vals[$];
  int          fails = 0;
  int          sent = 0;
  bit          gaps_on = 1'b1;
  bit          long_hold = 1'b0;

  // Fold the key count register into 1..NKEYS.
  function automatic int live_keys();
    if (key_count == 0) return 1;
    if (key_count > NKEYS) return NKEYS;
    return key_count;
  endfunction

  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [16:0] f);
    longint s;
    longint d;
    longint p;
    longint r;
    s = longint'(signed'(a));
    d = longint'(signed'(b)) - s;
    p = d * longint'(f);
    r = s + (p >>> 16);   // arithmetic shift gives the floor
    return r[31:0];
  endfunction

  function automatic kfi_pkg::out_item_t track_sample(logic [31:0] q);
    kfi_pkg::out_item_t r;
    int         n;
    int         seg;
    int         k;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [63:0] f;
    logic [16:0] fac;
    n = live_keys();
    seg = n;
    if (n > 1) begin
      for (int i = 0; i + 1 < n; i++) begin
        if (q < trk_time[i+1]) begin
          seg = i;
          break;
        end
      end
    end
    if (seg >= n) begin
      k = (n > 1) ? n - 1 : 0;
      r.out_x = trk_x[k];
      r.out_y = trk_y[k];
      r.out_z = trk_z[k];
      return r;
    end
    t0 = trk_time[seg];
    t1 = trk_time[seg+1];
    if (q <= t0 || t1 <= t0) begin
      fac = '0;
    end else begin
      f = {16'd0, q - t0, 16'd0} / {32'd0, t1 - t0};
      fac = (f > 64'h10000) ? kfi_pkg::Q_ONE : f[16:0];
    end
    r.out_x = blend(trk_x[seg], trk_x[seg+1], fac);
    r.out_y = blend(trk_y[seg], trk_y[seg+1], fac);
    r.out_z = blend(trk_z[seg], trk_z[seg+1], fac);
    return r;
  endfunction

  // Drive one transaction and hold it until taken; then update the track copy or queue the expected result.
  task automatic push_item(kfi_pkg::in_item_t it, bit typed, kfi_pkg::out_item_t want);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (it.func == kfi_pkg::FUNC_LOAD) begin
      trk_time[it.key_slot]   = it.key_time;
      trk_x[it.key_slot]      = it.key_x;
      trk_y[it.key_slot]      = it.key_y;
      trk_z[it.key_slot]      = it.key_z;
    end else begin
      pending_vals.insert(pending_vals.size(),
                          typed ? want : track_sample(it.query_time));
    end
  endtask

  // Write the key count only once the block has drained.
  task automatic set_key_count(logic [6:0] n);
    in_valid <= 1'b0;
    while (pending_vals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
    key_count = n;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 255) << 16;
      default: return $urandom();
    endcase
  endfunction

  function automatic kfi_pkg::in_item_t load_item(int slot, logic [31:0] t);
    kfi_pkg::in_item_t it;
    it.func       = kfi_pkg::FUNC_LOAD;
    it.key_slot   = slot[5:0];
    it.key_time   = t;
    it.key_x      = rand_val();
    it.key_y      = rand_val();
    it.key_z      = rand_val();
    it.query_time = $urandom();
    return it;
  endfunction

  function automatic kfi_pkg::in_item_t query_item(logic [31:0] q);
    kfi_pkg::in_item_t it;
    it = load_item($urandom_range(0, 63), $urandom());
    it.func = kfi_pkg::FUNC_QUERY;
    it.query_time = q;
    return it;
  endfunction

  // Directed table: config rows, loads and queries, some with typed answers.
  typedef struct {
    bit         is_cfg;
    logic [6:0] cnt;
    kfi_pkg::in_item_t  it;
    bit         typed;
    kfi_pkg::out_item_t want;
  } step_t;

  function automatic step_t ld(int slot, logic [31:0] t, logic [31:0] x,
                               logic [31:0] y, logic [31:0] z);
    step_t s;
    s = '{default: '0};
    s.it = '{kfi_pkg::FUNC_LOAD, slot[5:0], t, x, y, z, 32'hFFFF_FFFF};
    return s;
  endfunction

  function automatic step_t qr(logic [31:0] q, bit typed, kfi_pkg::out_item_t w);
    step_t s;
    s = '{default: '0};
    s.it = '{kfi_pkg::FUNC_QUERY, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, q};
    s.typed = typed;
    s.want = w;
    return s;
  endfunction

  function automatic step_t cf(logic [6:0] n);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.cnt = n;
    return s;
  endfunction

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    kfi_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_vals.size() == 0) begin
        $error("result transaction with nothing expected: %h", out_data);
        fails++;
      end else begin
        e = pending_vals.pop_front();
        if (out_data.out_x !== e.out_x) begin
          $error("out_x expected %h got %h", e.out_x, out_data.out_x);
          fails++;
        end
        if (out_data.out_y !== e.out_y) begin
          $error("out_y expected %h got %h", e.out_y, out_data.out_y);
          fails++;
        end
        if (out_data.out_z !== e.out_z) begin
          $error("out_z expected %h got %h", e.out_z, out_data.out_z);
          fails++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    step_t      dir[$];
    kfi_pkg::out_item_t k0;
    kfi_pkg::out_item_t k2;
    int         n;
    int         eff;
    int         nq;
    int         phase;
    logic [31:0] t;
    logic [31:0] q;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    key_count = 7'd1;
    for (int i = 0; i < NKEYS; i++) begin
      trk_time[i] = '0; trk_x[i] = '0; trk_y[i] = '0; trk_z[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    k0 = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345};
    k2 = '{32'h0000_0001, 32'h0000_0002, 32'h0000_0003};
    dir = {dir, ld(0, 32'h0, k0.out_x, k0.out_y, k0.out_z)};
    dir = {dir, qr(32'h0, 1, k0)};              // single key after reset
    dir = {dir, qr(32'hFFFF_FFFF, 1, k0)};
    dir = {dir, ld(1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0)};
    dir = {dir, ld(2, 32'h0002_0000, k2.out_x, k2.out_y, k2.out_z)}; // empty interval
    dir = {dir, ld(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000)};
    dir = {dir, cf(7'd3)};
    dir = {dir, qr(32'h0, 1, k0)};              // at the interval start
    dir = {dir, qr(32'h0001_0000, 0, k0)};
    dir = {dir, qr(32'h0001_FFFF, 0, k0)};
    dir = {dir, qr(32'h0002_0000, 1, k2)};      // at the last key time, then past it
    dir = {dir, qr(32'hFFFF_FFFF, 1, k2)};
    dir = {dir, cf(7'd0)};                      // zero acts as one key
    dir = {dir, qr(32'h0000_0005, 1, k0)};
    dir = {dir, cf(7'd2)};
    dir = {dir, qr(32'h0000_8000, 0, k0)};

    foreach (dir[i]) begin
      if (dir[i].is_cfg) set_key_count(dir[i].cnt);
      else push_item(dir[i].it, dir[i].typed, dir[i].want);
    end

    // Random phases: reload a monotonic track, set the count, then query it.
    phase = 0;
    while (sent < 1250) begin
      case ($urandom_range(0, 9))
        0: n = 64;
        1: n = 127;
        2: n = $urandom_range(0, 1);
        3: n = $urandom_range(9, 63);
        default: n = $urandom_range(2, 8);
      endcase
      if (phase == 3) n = 64;
      eff = (n == 0) ? 1 : (n > NKEYS ? NKEYS : n);
      if (sent > 1100) gaps_on = 1'b0;

      t = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, 32'h00FF_FFFF);
      for (int s = 0; s < eff; s++) begin
        push_item(load_item(s, t), 0, '0);
        case ($urandom_range(0, 4))
          0: ;                                          // repeat the time
          1: t = (t > 32'hFFFF_0000) ? t : t + $urandom_range(1, 16);
          default: t = (t > 32'hF000_0000) ? t : t + $urandom_range(1, 32'h0008_0000);
        endcase
      end
      set_key_count(n[6:0]);

      if (phase == 3) long_hold = 1'b1;   // receiver holds off, block fills
      nq = $urandom_range(15, 35);
      for (int j = 0; j < nq; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise load: any slot, any time
          push_item(load_item($urandom_range(0, 63), $urandom()), 0, '0);
          continue;
        end
        case ($urandom_range(0, 5))
          0: q = $urandom();
          1: q = trk_time[$urandom_range(0, eff - 1)];
          2: q = trk_time[$urandom_range(0, eff - 1)] - 1;
          default: q = $urandom_range(trk_time[0], trk_time[eff-1] + 32'h0001_0000);
        endcase
        push_item(query_item(q), 0, '0);
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_vals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
